/* rtl/core/owira_pkg.sv */
package owira_pkg;

    // Frame length thresholds
    localparam logic [7:0] MIN_FRAME_LEN = 8'd5;
    localparam logic [7:0] ID_FRAME_LEN  = 8'd12;

    // ID framing: 64 bits total, CRC over the first 56
    localparam int ID_BITS  = 64;
    localparam int CRC_BITS = 56;
    localparam int CNT_W    = 6;

    // Dallas CRC-8, reflected, x^8+x^5+x^4+1
    localparam logic [7:0] CRC_FEEDBACK = 8'h18;
    localparam logic [7:0] CRC_TOP_BIT  = 8'h80;

    // GPIO group (pin / 8) to data byte lane
    localparam logic [1:0] LANE_OF_GROUP [4] = '{2'd2, 2'd3, 2'd0, 2'd1};

    localparam int QUEUE_DEPTH_DEF = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIN_NUMBER      = 3'd0,
        CFG_ID_TRANSACTION  = 3'd1,
        CFG_SUPERVISORY     = 3'd2,
        CFG_FRAME_TYPE_MASK = 3'd3,
        CFG_REJECT_CODE     = 3'd4,
        CFG_SREJECT_CODE    = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [4:0] pin_number;
        logic [7:0] id_transaction;
        logic [7:0] supervisory_mask;
        logic [7:0] frame_type_mask;
        logic [7:0] reject_code;
        logic [7:0] selective_reject_code;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        pin_number:            5'd0,
        id_transaction:        8'd254,
        supervisory_mask:      8'd1,
        frame_type_mask:       8'd12,
        reject_code:           8'd4,
        selective_reject_code: 8'd12
    };

    // Classified frame, passed from front to back through the queue
    typedef struct packed {
        logic used;
        logic cmd_error;
        logic reject_error;
        logic fcs_error;
        logic id_hit;
        logic id_bit;
    } t_item;

    typedef struct packed {
        logic       frame_used;
        logic       cmd_error;
        logic       reject_error;
        logic       fcs_error;
        logic       error_seen;
        logic       byte_ready;
        logic [2:0] byte_index;
        logic [7:0] id_byte;
        logic       id_complete;
        logic       crc_matches;
        logic [7:0] computed_crc;
    } t_result;

    function automatic logic [7:0] crc8_bit(input logic [7:0] crc, input logic b);
        logic [7:0] res;
        if (crc[0] ^ b) begin
            res = ((crc ^ CRC_FEEDBACK) >> 1) | CRC_TOP_BIT;
        end else begin
            res = crc >> 1;
        end
        return res;
    endfunction

endpackage

/* rtl/core/owira_front.sv */
module owira_front
    import owira_pkg::*;
(
    input  t_cfg       i_cfg,
    input  logic [7:0] i_frame_length,
    input  logic [7:0] i_control_byte,
    input  logic [7:0] i_transaction_id,
    input  logic [7:0] i_error_byte,
    input  logic [7:0] i_data_byte0,
    input  logic [7:0] i_data_byte1,
    input  logic [7:0] i_data_byte2,
    input  logic [7:0] i_data_byte3,
    input  logic       i_frame_check_ok,
    output t_item      o_item
);

    logic [7:0] lanes [4];
    logic [7:0] sel_lane;
    logic [7:0] frame_type;
    logic       used;
    logic       is_sframe;

    assign lanes[0] = i_data_byte0;
    assign lanes[1] = i_data_byte1;
    assign lanes[2] = i_data_byte2;
    assign lanes[3] = i_data_byte3;

    assign sel_lane   = lanes[LANE_OF_GROUP[i_cfg.pin_number[4:3]]];
    assign frame_type = i_control_byte & i_cfg.frame_type_mask;
    assign used       = (i_frame_length >= MIN_FRAME_LEN);
    assign is_sframe  = |(i_control_byte & i_cfg.supervisory_mask);

    always_comb begin
        o_item.used         = used;
        o_item.cmd_error    = used && (i_error_byte != 8'd0);
        o_item.reject_error = used && is_sframe &&
                              ((frame_type == i_cfg.reject_code) ||
                               (frame_type == i_cfg.selective_reject_code));
        o_item.fcs_error    = used && !i_frame_check_ok;
        // 12-byte length already implies a used frame
        o_item.id_hit       = (i_frame_length == ID_FRAME_LEN) &&
                              (i_transaction_id == i_cfg.id_transaction);
        o_item.id_bit       = sel_lane[i_cfg.pin_number[2:0]];
    end

endmodule

/* rtl/core/owira_queue.sv */
module owira_queue
    import owira_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    output logic  o_valid,
    input  logic  i_pop,
    output t_item o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_QW-1:0] r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_QW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_QW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_QW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_QW'(DEPTH))
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers apart while empty");

endmodule

/* rtl/core/owira_back.sv */
module owira_back
    import owira_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_item   i_item,
    output logic    o_pop,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_result o_result
);

    logic [7:0]       r_shift, n_shift;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_crc, n_crc;
    logic             r_err, n_err;
    logic             r_out_valid;
    t_result          r_out, n_out;

    logic [7:0] shifted;
    logic       last_bit;

    // Output slot is free when empty or being taken this cycle
    assign o_pop       = i_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    assign shifted  = {i_item.id_bit, r_shift[7:1]};
    assign last_bit = (r_cnt == CNT_W'(ID_BITS - 1));

    always_comb begin
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_crc   = r_crc;
        n_err   = r_err || i_item.cmd_error || i_item.reject_error || i_item.fcs_error;
        n_out   = '0;

        n_out.frame_used   = i_item.used;
        n_out.cmd_error    = i_item.cmd_error;
        n_out.reject_error = i_item.reject_error;
        n_out.fcs_error    = i_item.fcs_error;
        n_out.error_seen   = n_err;

        if (i_item.id_hit) begin
            n_shift = shifted;
            if (r_cnt < CNT_W'(CRC_BITS)) begin
                n_crc = crc8_bit(r_crc, i_item.id_bit);
            end
            if (r_cnt[2:0] == 3'd7) begin
                n_out.byte_ready = 1'b1;
                n_out.byte_index = r_cnt[5:3];
                n_out.id_byte    = shifted;
                n_shift          = '0;
            end
            if (last_bit) begin
                // CRC stops after bit 55, so r_crc is the final value here
                n_out.id_complete  = 1'b1;
                n_out.computed_crc = r_crc;
                n_out.crc_matches  = (shifted == r_crc);
                n_crc              = '0;
                n_cnt              = '0;
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_cnt       <= '0;
            r_crc       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_shift <= n_shift;
                r_cnt   <= n_cnt;
                r_crc   <= n_crc;
                r_err   <= n_err;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    a_byte_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt[2:0] == 3'd0) |-> (r_shift == 8'd0))
        else $error("shift byte not clear at byte boundary");

    a_complete_last_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.id_complete) |->
            (r_out.byte_ready && (r_out.byte_index == 3'd7)))
        else $error("ID complete without last byte");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("sticky error flag dropped");

    a_wrap_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_item.id_hit && last_bit) |=> ((r_cnt == '0) && (r_crc == 8'd0)))
        else $error("ID state not cleared after last bit");

endmodule

/* rtl/core/onewire_id_reply_assembler_unit.sv */
// 1-Wire ROM ID reply assembler.
// Input channel: one reply frame summary per beat (i_in_valid / o_in_stall).
// The front classifies the frame (used, command error, reject, frame check,
// ID bit from the configured GPIO pin) and pushes it into a small queue.
// The back pops one entry per cycle while the output slot is free (empty
// or being taken), shifts the ID bit in LSB first, runs the Dallas CRC-8
// over bits 0..55 and compares byte 7 with it at bit 63. Output channel:
// one result beat per input beat (o_out_valid / i_out_stall), held in an
// output register. An accepted beat waits in the queue until the back pops
// it into the output register. Throughput: one beat per cycle; the queue
// absorbs stalls on the output, and o_in_stall rises only when the queue is full.
// Config: write port i_cfg_valid / o_cfg_ready (always ready), register index
// on i_cfg_index, data on i_cfg_data; unknown indexes are dropped. Write only
// while the block is idle.
// Reset (synchronous, active low): config to defaults, ID shift state,
// CRC and sticky error cleared, queue and output register emptied.
module onewire_id_reply_assembler_unit
    import owira_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_frame_length,
    input  logic [7:0]            i_control_byte,
    input  logic [7:0]            i_transaction_id,
    input  logic [7:0]            i_error_byte,
    input  logic [7:0]            i_data_byte0,
    input  logic [7:0]            i_data_byte1,
    input  logic [7:0]            i_data_byte2,
    input  logic [7:0]            i_data_byte3,
    input  logic                  i_frame_check_ok,

    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_frame_used,
    output logic                  o_cmd_error,
    output logic                  o_reject_error,
    output logic                  o_fcs_error,
    output logic                  o_error_seen,
    output logic                  o_byte_ready,
    output logic [2:0]            o_byte_index,
    output logic [7:0]            o_id_byte,
    output logic                  o_id_complete,
    output logic                  o_crc_matches,
    output logic [7:0]            o_computed_crc,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg, n_cfg;
    t_item   front_item;
    t_item   queue_item;
    logic    queue_full;
    logic    queue_valid;
    logic    back_pop;
    t_result result;

    // ---- configuration registers ----
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PIN_NUMBER:      n_cfg.pin_number            = i_cfg_data[4:0];
                CFG_ID_TRANSACTION:  n_cfg.id_transaction        = i_cfg_data;
                CFG_SUPERVISORY:     n_cfg.supervisory_mask      = i_cfg_data;
                CFG_FRAME_TYPE_MASK: n_cfg.frame_type_mask       = i_cfg_data;
                CFG_REJECT_CODE:     n_cfg.reject_code           = i_cfg_data;
                CFG_SREJECT_CODE:    n_cfg.selective_reject_code = i_cfg_data;
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // ---- front: classify ----
    owira_front u_front (
        .i_cfg            (r_cfg),
        .i_frame_length   (i_frame_length),
        .i_control_byte   (i_control_byte),
        .i_transaction_id (i_transaction_id),
        .i_error_byte     (i_error_byte),
        .i_data_byte0     (i_data_byte0),
        .i_data_byte1     (i_data_byte1),
        .i_data_byte2     (i_data_byte2),
        .i_data_byte3     (i_data_byte3),
        .i_frame_check_ok (i_frame_check_ok),
        .o_item           (front_item)
    );

    // ---- queue between front and back ----
    assign o_in_stall = queue_full;

    owira_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid),
        .i_item  (front_item),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (back_pop),
        .o_item  (queue_item)
    );

    // ---- back: ID assembly, CRC, output register ----
    owira_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .i_item      (queue_item),
        .o_pop       (back_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_frame_used   = result.frame_used;
    assign o_cmd_error    = result.cmd_error;
    assign o_reject_error = result.reject_error;
    assign o_fcs_error    = result.fcs_error;
    assign o_error_seen   = result.error_seen;
    assign o_byte_ready   = result.byte_ready;
    assign o_byte_index   = result.byte_index;
    assign o_id_byte      = result.id_byte;
    assign o_id_complete  = result.id_complete;
    assign o_crc_matches  = result.crc_matches;
    assign o_computed_crc = result.computed_crc;

endmodule

/* tb/sv/onewire_id_reply_assembler_unit_tb.sv */
`timescale 1ns / 1ps

module onewire_id_reply_assembler_unit_tb;
    import owira_pkg::*;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int          CYCLE_LIMIT      = 200000;  // far above the slowest legal run
    localparam int          RESET_CYCLES     = 12;
    localparam int          IDLE_PCT         = 22;      // idle share on each side
    localparam int          LONG_HOLD        = 60;      // receiver hold-off, in cycles
    localparam int          PHASE_FRAMES     = 130;     // random beats per phase
    localparam int          TAIL_CYCLES      = 8;       // quiet time after the last reply
    // Reflected Dallas polynomial x^8+x^5+x^4+1, applied after the shift
    localparam logic [7:0]  DALLAS_POLY_REFL = 8'h8C;
    // Register indexes past the end of the list; the block must drop them
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    // One reply frame summary, as driven on the input ports
    typedef struct packed {
        logic [7:0] len;
        logic [7:0] ctrl;
        logic [7:0] trid;
        logic [7:0] err;
        logic [7:0] d0;
        logic [7:0] d1;
        logic [7:0] d2;
        logic [7:0] d3;
        logic       fcs_ok;
    } t_frame_summary;

    // ------------------------------------------------------------------
    // Reply predictor and checker: keeps its own copy of the registers
    // and of the ID shift / CRC state, predicts one reply per accepted
    // beat and checks the replies in order.
    // ------------------------------------------------------------------
    class reply_checker;
        logic [4:0]  pin;
        logic [7:0]  id_trans;
        logic [7:0]  sup_mask;
        logic [7:0]  type_mask;
        logic [7:0]  rej_code;
        logic [7:0]  srej_code;

        logic [7:0]  shift_reg;
        int unsigned bits_taken;
        logic [7:0]  crc_acc;
        logic        err_sticky;

        t_result     expected_replies[$];
        int unsigned mismatches;
        int unsigned replies_seen;
        int unsigned n_short, n_rejects, n_bytes, n_ids, n_crc_good, n_settings;

        function new();
            pin        = CFG_RESET.pin_number;
            id_trans   = CFG_RESET.id_transaction;
            sup_mask   = CFG_RESET.supervisory_mask;
            type_mask  = CFG_RESET.frame_type_mask;
            rej_code   = CFG_RESET.reject_code;
            srej_code  = CFG_RESET.selective_reject_code;
            shift_reg  = '0;
            bits_taken = 0;
            crc_acc    = '0;
            err_sticky = 1'b0;
        endfunction

        static function logic [7:0] crc_step(logic [7:0] crc, logic b);
            logic fb;
            fb = crc[0] ^ b;
            return (crc >> 1) ^ (fb ? DALLAS_POLY_REFL : 8'h00);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_PIN_NUMBER:      pin       = val[4:0];
                CFG_ID_TRANSACTION:  id_trans  = val;
                CFG_SUPERVISORY:     sup_mask  = val;
                CFG_FRAME_TYPE_MASK: type_mask = val;
                CFG_REJECT_CODE:     rej_code  = val;
                CFG_SREJECT_CODE:    srej_code = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        function void note_frame(t_frame_summary f);
            t_result     r;
            logic [31:0] gpio;
            logic [7:0]  ftype;
            logic        b;
            r    = '0;
            gpio = {f.d1, f.d0, f.d3, f.d2};
            if (f.len >= MIN_FRAME_LEN) begin
                r.frame_used = 1'b1;
                r.cmd_error  = (f.err != 8'h00);
                if ((f.ctrl & sup_mask) != 8'h00) begin
                    ftype          = f.ctrl & type_mask;
                    r.reject_error = (ftype == rej_code) || (ftype == srej_code);
                end
                r.fcs_error = !f.fcs_ok;
                if (r.cmd_error || r.reject_error || r.fcs_error) begin
                    err_sticky = 1'b1;
                end
                // errors do not stop the ID bit from being taken
                if (f.len == ID_FRAME_LEN && f.trid == id_trans) begin
                    b         = gpio[pin];
                    shift_reg = {b, shift_reg[7:1]};
                    if (bits_taken < CRC_BITS) begin
                        crc_acc = crc_step(crc_acc, b);
                    end
                    if (bits_taken[2:0] == 3'd7) begin
                        r.byte_ready = 1'b1;
                        r.byte_index = bits_taken[5:3];
                        r.id_byte    = shift_reg;
                        shift_reg    = '0;
                        n_bytes++;
                    end
                    if (bits_taken == ID_BITS - 1) begin
                        r.id_complete  = 1'b1;
                        r.computed_crc = crc_acc;
                        r.crc_matches  = (r.id_byte == crc_acc);
                        crc_acc        = '0;
                        bits_taken     = 0;
                        n_ids++;
                        if (r.crc_matches) n_crc_good++;
                    end else begin
                        bits_taken++;
                    end
                end
            end else begin
                n_short++;
            end
            if (r.reject_error) n_rejects++;
            r.error_seen = err_sticky;
            expected_replies.push_back(r);
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [7:0] got_v, logic [7:0] exp_v);
            if (got_v !== exp_v) begin
                report($sformatf("reply %0d %s: got 0x%0h, expected 0x%0h",
                                 replies_seen, name, got_v, exp_v));
            end
        endtask

        task check_reply(t_result got);
            t_result e;
            if (expected_replies.size() == 0) begin
                report($sformatf("reply %0d arrived with nothing expected", replies_seen));
            end else begin
                e = expected_replies.pop_front();
                check_field("frame_used",   8'(got.frame_used),   8'(e.frame_used));
                check_field("cmd_error",    8'(got.cmd_error),    8'(e.cmd_error));
                check_field("reject_error", 8'(got.reject_error), 8'(e.reject_error));
                check_field("fcs_error",    8'(got.fcs_error),    8'(e.fcs_error));
                check_field("error_seen",   8'(got.error_seen),   8'(e.error_seen));
                check_field("byte_ready",   8'(got.byte_ready),   8'(e.byte_ready));
                check_field("byte_index",   8'(got.byte_index),   8'(e.byte_index));
                check_field("id_byte",      got.id_byte,          e.id_byte);
                check_field("id_complete",  8'(got.id_complete),  8'(e.id_complete));
                check_field("crc_matches",  8'(got.crc_matches),  8'(e.crc_matches));
                check_field("computed_crc", got.computed_crc,     e.computed_crc);
            end
            replies_seen++;
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [7:0]            i_frame_length;
    logic [7:0]            i_control_byte;
    logic [7:0]            i_transaction_id;
    logic [7:0]            i_error_byte;
    logic [7:0]            i_data_byte0;
    logic [7:0]            i_data_byte1;
    logic [7:0]            i_data_byte2;
    logic [7:0]            i_data_byte3;
    logic                  i_frame_check_ok;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_frame_used;
    logic                  o_cmd_error;
    logic                  o_reject_error;
    logic                  o_fcs_error;
    logic                  o_error_seen;
    logic                  o_byte_ready;
    logic [2:0]            o_byte_index;
    logic [7:0]            o_id_byte;
    logic                  o_id_complete;
    logic                  o_crc_matches;
    logic [7:0]            o_computed_crc;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    onewire_id_reply_assembler_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_frame_length   (i_frame_length),
        .i_control_byte   (i_control_byte),
        .i_transaction_id (i_transaction_id),
        .i_error_byte     (i_error_byte),
        .i_data_byte0     (i_data_byte0),
        .i_data_byte1     (i_data_byte1),
        .i_data_byte2     (i_data_byte2),
        .i_data_byte3     (i_data_byte3),
        .i_frame_check_ok (i_frame_check_ok),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_frame_used     (o_frame_used),
        .o_cmd_error      (o_cmd_error),
        .o_reject_error   (o_reject_error),
        .o_fcs_error      (o_fcs_error),
        .o_error_seen     (o_error_seen),
        .o_byte_ready     (o_byte_ready),
        .o_byte_index     (o_byte_index),
        .o_id_byte        (o_id_byte),
        .o_id_complete    (o_id_complete),
        .o_crc_matches    (o_crc_matches),
        .o_computed_crc   (o_computed_crc),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Testbench state
    // ------------------------------------------------------------------
    reply_checker replies;
    int           feed_pct;      // sender idle share, percent
    int           stall_pct;     // receiver stall share, percent
    bit           hold_request;  // ask the stall process for one long hold-off
    int           hold_left;
    int unsigned  cycle_count;
    logic [63:0]  rom_id;        // ROM ID currently being fed bit by bit
    int           id_pos;        // next ID bit to feed

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, replies.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver back-pressure. Random stalls, or a long hold-off counted
    // here so the sender keeps going and the block's queue fills up.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // Reply monitor: a beat moves at a rising edge with valid high and
    // stall low; outputs are read before this edge's updates land.
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.frame_used   = o_frame_used;
            got.cmd_error    = o_cmd_error;
            got.reject_error = o_reject_error;
            got.fcs_error    = o_fcs_error;
            got.error_seen   = o_error_seen;
            got.byte_ready   = o_byte_ready;
            got.byte_index   = o_byte_index;
            got.id_byte      = o_id_byte;
            got.id_complete  = o_id_complete;
            got.crc_matches  = o_crc_matches;
            got.computed_crc = o_computed_crc;
            replies.check_reply(got);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // 7 random bytes and their CRC-8 as byte 7; now and then a bad CRC byte
    function automatic logic [63:0] make_rom_id();
        logic [63:0] v;
        logic [7:0]  c;
        v = {$urandom, $urandom};
        c = 8'h00;
        for (int n = 0; n < CRC_BITS; n++) begin
            c = reply_checker::crc_step(c, v[n]);
        end
        v[63:56] = ($urandom_range(9) == 0) ? 8'($urandom) : c;
        return v;
    endfunction

    // GPIO word order on the wire: bits 0-7 in byte 2, 8-15 in byte 3,
    // 16-23 in byte 0, 24-31 in byte 1
    function automatic t_frame_summary make_frame(logic [7:0] len, logic [7:0] ctrl,
                                                  logic [7:0] trid, logic [7:0] err,
                                                  logic [31:0] gpio, logic fcs_ok);
        t_frame_summary f;
        f.len    = len;
        f.ctrl   = ctrl;
        f.trid   = trid;
        f.err    = err;
        f.d2     = gpio[7:0];
        f.d3     = gpio[15:8];
        f.d0     = gpio[23:16];
        f.d1     = gpio[31:24];
        f.fcs_ok = fcs_ok;
        return f;
    endfunction

    // Mostly ID frames that carry the current ROM ID bit by bit; the rest
    // short frames and raw noise. Errors ride along on some ID frames.
    function automatic t_frame_summary next_random_frame();
        int unsigned    pick;
        logic [31:0]    gpio;
        logic [7:0]     err;
        t_frame_summary f;
        pick = $urandom_range(99);
        gpio = $urandom;
        if (pick < 75) begin
            gpio[replies.pin] = rom_id[id_pos];
            if ($urandom_range(49) == 0) begin
                gpio[replies.pin] = ~rom_id[id_pos];   // broken sequence
            end
            err = ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00;
            f   = make_frame(ID_FRAME_LEN, 8'($urandom), replies.id_trans, err, gpio,
                             $urandom_range(9) != 0);
        end else if (pick < 85) begin
            f = make_frame(8'($urandom_range(0, MIN_FRAME_LEN - 1)), 8'($urandom),
                           8'($urandom), 8'($urandom), gpio, 1'($urandom_range(1)));
        end else begin
            f = make_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), gpio,
                           1'($urandom_range(1)));
        end
        return f;
    endfunction

    // Offer one beat, wait for acceptance, record the prediction. Entered
    // and left at a falling edge; valid stays high into the next beat.
    task automatic send_frame(t_frame_summary f);
        while (feed_pct != 0 && $urandom_range(99) < feed_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_frame_length   <= f.len;
        i_control_byte   <= f.ctrl;
        i_transaction_id <= f.trid;
        i_error_byte     <= f.err;
        i_data_byte0     <= f.d0;
        i_data_byte1     <= f.d1;
        i_data_byte2     <= f.d2;
        i_data_byte3     <= f.d3;
        i_frame_check_ok <= f.fcs_ok;
        i_in_valid       <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        replies.note_frame(f);
        // keep the ID feed aligned with what the block has taken
        if (f.len == ID_FRAME_LEN && f.trid == replies.id_trans) begin
            id_pos++;
            if (id_pos == ID_BITS) begin
                id_pos = 0;
                rom_id = make_rom_id();
            end
        end
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted reply has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (replies.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One register beat; valid is left high for back-to-back writes
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        replies.write_reg(idx, val);
        @(negedge i_clk);
    endtask

    // Full register set, plus junk to the unused indexes. Upper pin bits
    // are random to check the 5-bit masking.
    task automatic apply_settings(logic [4:0] pin, logic [7:0] idtr, logic [7:0] sup,
                                  logic [7:0] ftype, logic [7:0] rej, logic [7:0] srej);
        write_reg(CFG_PIN_NUMBER,      {3'($urandom), pin});
        write_reg(CFG_ID_TRANSACTION,  idtr);
        write_reg(CFG_SUPERVISORY,     sup);
        write_reg(CFG_FRAME_TYPE_MASK, ftype);
        write_reg(CFG_REJECT_CODE,     rej);
        write_reg(CFG_SREJECT_CODE,    srej);
        write_reg(CFG_IDX_SPARE_LO,    8'($urandom));
        write_reg(CFG_IDX_SPARE_HI,    8'($urandom));
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        replies.n_settings++;
    endtask

    // Random beats; optionally pause the sender mid-way until drained
    task automatic run_random(int count, int pause_at);
        for (int k = 0; k < count; k++) begin
            if (k == pause_at) wait_drained();
            send_frame(next_random_frame());
        end
    endtask

    // Directed beats at reset settings: pin 0 (byte 2 bit 0), ID
    // transaction 254, S-frame bit 0, type in bits 2-3, REJ 4, SREJ 12
    task automatic run_directed();
        logic [7:0] idt;
        idt = CFG_RESET.id_transaction;
        // short frames: ignored, nothing flagged even with junk fields
        send_frame(make_frame(8'd0,   8'h00, 8'h00, 8'h00, 32'h0000_0000, 1'b1));
        send_frame(make_frame(8'd4,   8'hFF, idt,   8'hFF, 32'hFFFF_FFFF, 1'b0));
        // length edges, clean
        send_frame(make_frame(8'd5,   8'h00, 8'h00, 8'h00, 32'h0000_0000, 1'b1));
        send_frame(make_frame(8'd255, 8'h00, idt,   8'h00, 32'hFFFF_FFFF, 1'b1));
        send_frame(make_frame(8'd13,  8'h00, idt,   8'h00, 32'hFFFF_FFFF, 1'b1));
        send_frame(make_frame(8'd11,  8'h00, idt,   8'h00, 32'hFFFF_FFFF, 1'b1));
        // ID bits: one, wrong transaction id, zero, one with a command error
        send_frame(make_frame(ID_FRAME_LEN, 8'h00, idt,   8'h00, 32'h0000_0001, 1'b1));
        send_frame(make_frame(ID_FRAME_LEN, 8'h00, 8'hFD, 8'h00, 32'hFFFF_FFFF, 1'b1));
        send_frame(make_frame(ID_FRAME_LEN, 8'h00, idt,   8'h00, 32'h0000_0000, 1'b1));
        send_frame(make_frame(ID_FRAME_LEN, 8'h00, idt,   8'hFF, 32'hFFFF_FFFF, 1'b1));
        // reject, selective reject, I-frame with reject type bits, all ones
        send_frame(make_frame(8'd5, 8'h05, 8'h00, 8'h00, 32'h0, 1'b1));
        send_frame(make_frame(8'd5, 8'h0D, 8'h00, 8'h00, 32'h0, 1'b1));
        send_frame(make_frame(8'd5, 8'h0C, 8'h00, 8'h00, 32'h0, 1'b1));
        send_frame(make_frame(8'd5, 8'hFF, 8'h00, 8'h00, 32'h0, 1'b1));
        // frame check failure, then a short frame shows the sticky flag
        send_frame(make_frame(8'd5, 8'h00, 8'h00, 8'h00, 32'h0, 1'b0));
        send_frame(make_frame(8'd4, 8'h00, 8'h00, 8'h00, 32'h0, 1'b1));
        // five more ID bits finish byte 0
        send_frame(make_frame(ID_FRAME_LEN, 8'h00, idt, 8'h00, 32'hFFFF_FFFE, 1'b1));
        send_frame(make_frame(ID_FRAME_LEN, 8'h00, idt, 8'h00, 32'h0000_0001, 1'b1));
        send_frame(make_frame(ID_FRAME_LEN, 8'h01, idt, 8'h00, 32'h0000_0001, 1'b0));
        send_frame(make_frame(ID_FRAME_LEN, 8'h00, idt, 8'h00, 32'hFFFF_FFFE, 1'b1));
        send_frame(make_frame(ID_FRAME_LEN, 8'h00, idt, 8'h00, 32'hFFFF_FFFF, 1'b1));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [7:0] ftype;
        replies      = new();
        rom_id       = make_rom_id();
        id_pos       = 0;
        feed_pct     = 0;
        stall_pct    = 0;
        hold_request = 1'b0;
        hold_left    = 0;
        cycle_count  = 0;

        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_out_stall      = 1'b0;
        i_frame_length   = '0;
        i_control_byte   = '0;
        i_transaction_id = '0;
        i_error_byte     = '0;
        i_data_byte0     = '0;
        i_data_byte1     = '0;
        i_data_byte2     = '0;
        i_data_byte3     = '0;
        i_frame_check_ok = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings, directed corners, no idling
        run_directed();
        wait_drained();

        // Extremes: top pin, zero id, every control bit an S-frame type bit
        feed_pct  = IDLE_PCT;
        stall_pct = IDLE_PCT;
        apply_settings(5'd31, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF);
        run_random(PHASE_FRAMES, -1);
        wait_drained();

        // Opposite extremes, and a long stretch at full rate both ways
        feed_pct  = 0;
        stall_pct = 0;
        apply_settings(5'd0, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00);
        run_random(PHASE_FRAMES, -1);
        wait_drained();

        // Random settings; receiver holds off long while beats keep coming
        feed_pct  = IDLE_PCT;
        stall_pct = IDLE_PCT;
        ftype     = 8'($urandom);
        apply_settings(5'($urandom_range(8, 23)), 8'($urandom), 8'($urandom), ftype,
                       8'($urandom) & ftype, 8'($urandom) & ftype);
        hold_request = 1'b1;
        run_random(PHASE_FRAMES, -1);
        wait_drained();

        // Random settings; sender pauses mid-phase until drained
        ftype = 8'($urandom);
        apply_settings(5'($urandom), 8'($urandom), 8'($urandom), ftype,
                       8'($urandom) & ftype, 8'($urandom) & ftype);
        run_random(PHASE_FRAMES, PHASE_FRAMES / 2);
        wait_drained();

        // Back to the reset values, written explicitly
        apply_settings(CFG_RESET.pin_number, CFG_RESET.id_transaction,
                       CFG_RESET.supervisory_mask, CFG_RESET.frame_type_mask,
                       CFG_RESET.reject_code, CFG_RESET.selective_reject_code);
        hold_request = 1'b1;
        run_random(PHASE_FRAMES, -1);
        wait_drained();

        // let any stray reply show up before the verdict
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Summary: %0d replies over %0d register settings, %0d short frames, %0d rejects",
                 replies.replies_seen, replies.n_settings, replies.n_short,
                 replies.n_rejects);
        $display("Summary: %0d ID bytes, %0d full IDs (%0d CRC-8 good), %0d mismatches",
                 replies.n_bytes, replies.n_ids, replies.n_crc_good, replies.mismatches);
        if (replies.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/owira_pkg.sv
rtl/core/owira_front.sv
rtl/core/owira_queue.sv
rtl/core/owira_back.sv
rtl/core/onewire_id_reply_assembler_unit.sv
tb/sv/onewire_id_reply_assembler_unit_tb.sv
